// File: rtl/rqp_pkg.sv
// Shared types and constants for the regex quantifier parser.
package rqp_pkg;

	localparam int OUT_W = 16;
	localparam int CNT_W = 8;

	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LOWER,
		PH_COMMA,
		PH_UPPER
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_UPPER_BELOW = 3'd1,
		ST_NO_BRACE    = 3'd2,
		ST_BAD_COMMA   = 3'd3,
		ST_BAD_LOWER   = 3'd4
	} status_t;

	typedef struct packed {
		logic [OUT_W-1:0] rep_min;
		logic [OUT_W-1:0] rep_max;
		logic             unbounded;
		status_t          status;
		logic [CNT_W-1:0] chars_consumed;
	} result_t;

endpackage

// File: rtl/rqp_step.sv
// Parser state registers and the per-character next-state and result logic.
module rqp_step #(
	parameter int NUMBER_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       character,
	output logic             res_valid,
	output rqp_pkg::result_t res
);

	localparam int ACC_W = (NUMBER_WIDTH >= 16) ? 16 : NUMBER_WIDTH;
	localparam int SUM_W = ACC_W + 4;

	rqp_pkg::phase_t phase_q, phase_d;
	logic [ACC_W-1:0] lower_q, lower_d;
	logic [ACC_W-1:0] upper_q, upper_d;
	logic [rqp_pkg::CNT_W-1:0] count_q, count_d, count_inc;
	logic digit;
	logic [ACC_W-1:0] dval;
	logic [ACC_W-1:0] lower_acc, upper_acc;
	logic fire;

	function automatic logic [ACC_W-1:0] acc10(input logic [ACC_W-1:0] acc,
		input logic [ACC_W-1:0] d);
		logic [SUM_W-1:0] sum;
		sum = (SUM_W'(acc) << 3) + (SUM_W'(acc) << 1) + SUM_W'(d);
		if (sum[SUM_W-1:ACC_W] != 4'd0)
			acc10 = {ACC_W{1'b1}};
		else
			acc10 = sum[ACC_W-1:0];
	endfunction

	assign digit     = (character >= rqp_pkg::CH_ZERO) && (character <= rqp_pkg::CH_NINE);
	assign dval      = ACC_W'(character[3:0]);
	assign lower_acc = acc10(lower_q, dval);
	assign upper_acc = acc10(upper_q, dval);
	assign count_inc = (count_q == {rqp_pkg::CNT_W{1'b1}}) ? count_q : count_q + 1'b1;

	always_comb begin
		phase_d            = phase_q;
		lower_d            = lower_q;
		upper_d            = upper_q;
		count_d            = count_q;
		fire               = 1'b0;
		res.rep_min        = 16'(lower_q);
		res.rep_max        = 16'(upper_q);
		res.unbounded      = 1'b0;
		res.status         = rqp_pkg::ST_OK;
		res.chars_consumed = count_q;
		unique case (phase_q)
			rqp_pkg::PH_LOWER: begin
				if (digit) begin
					lower_d = lower_acc;
					count_d = count_inc;
				end else if (character == rqp_pkg::CH_RBRACE) begin
					// exact count: both bounds take the lower value
					fire               = 1'b1;
					res.rep_max        = 16'(lower_q);
					res.chars_consumed = count_inc;
				end else if (character == rqp_pkg::CH_COMMA) begin
					phase_d = rqp_pkg::PH_COMMA;
					count_d = count_inc;
				end else begin
					fire        = 1'b1;
					res.rep_max = '0;
					res.status  = rqp_pkg::ST_BAD_LOWER;
				end
			end
			rqp_pkg::PH_COMMA: begin
				if (character == rqp_pkg::CH_RBRACE) begin
					fire               = 1'b1;
					res.rep_max        = '1;
					res.unbounded      = 1'b1;
					res.chars_consumed = count_inc;
				end else if (digit) begin
					phase_d = rqp_pkg::PH_UPPER;
					upper_d = dval;
					count_d = count_inc;
				end else begin
					fire        = 1'b1;
					res.rep_max = '0;
					res.status  = rqp_pkg::ST_BAD_COMMA;
				end
			end
			rqp_pkg::PH_UPPER: begin
				if (digit) begin
					upper_d = upper_acc;
					count_d = count_inc;
				end else if (upper_q < lower_q) begin
					fire       = 1'b1;
					res.status = rqp_pkg::ST_UPPER_BELOW;
				end else if (character != rqp_pkg::CH_RBRACE) begin
					fire       = 1'b1;
					res.status = rqp_pkg::ST_NO_BRACE;
				end else begin
					fire               = 1'b1;
					res.chars_consumed = count_inc;
				end
			end
			default: begin
				// idle: every parse starts from a clean count
				lower_d            = '0;
				upper_d            = '0;
				count_d            = '0;
				res.chars_consumed = 8'd1;
				res.rep_min        = 16'd0;
				case (character)
					rqp_pkg::CH_QUESTION: begin
						fire        = 1'b1;
						res.rep_max = 16'd1;
					end
					rqp_pkg::CH_STAR: begin
						fire          = 1'b1;
						res.rep_max   = '1;
						res.unbounded = 1'b1;
					end
					rqp_pkg::CH_PLUS: begin
						fire          = 1'b1;
						res.rep_min   = 16'd1;
						res.rep_max   = '1;
						res.unbounded = 1'b1;
					end
					rqp_pkg::CH_LBRACE: begin
						phase_d = rqp_pkg::PH_LOWER;
						count_d = 8'd1;
					end
					default: begin
						fire               = 1'b1;
						res.rep_min        = 16'd1;
						res.rep_max        = 16'd1;
						res.chars_consumed = 8'd0;
					end
				endcase
			end
		endcase
		// a finished parse drops back to idle with cleared accumulators
		if (fire) begin
			phase_d = rqp_pkg::PH_IDLE;
			lower_d = '0;
			upper_d = '0;
			count_d = '0;
		end
	end

	assign res_valid = accept && fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rqp_pkg::PH_IDLE;
			lower_q <= '0;
			upper_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			lower_q <= lower_d;
			upper_q <= upper_d;
			count_q <= count_d;
		end
	end

endmodule

// File: rtl/rqp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module rqp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rqp_pkg::result_t push_data,
	output logic             space,
	output logic             out_valid,
	input  logic             out_ready,
	output rqp_pkg::result_t head
);

	rqp_pkg::result_t head_q, skid_q;
	logic head_v_q, skid_v_q;
	logic pop;

	assign pop       = head_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = head_v_q;
	assign head      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) skid_v_q <= 1'b0;
		end else if (push) begin
			if (head_v_q && !pop) skid_v_q <= 1'b1;
			else head_v_q <= 1'b1;
		end else if (pop) begin
			head_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) head_q <= skid_q;
		end else if (push) begin
			if (head_v_q && !pop) skid_q <= push_data;
			else head_q <= push_data;
		end
	end

endmodule

// File: rtl/regex_quantifier_parser_unit.sv
// The result of the character that ends the parse is registered in the output buffer before it reaches the outputs.
// Throughput: one character per cycle while the output buffer has space; characters inside a brace give no result.
// A two-entry output buffer holds one extra result while the output stalls, so input flows until the skid fills.
// Reset: arst_n asynchronously clears the parser to idle and empties the buffer.
// Bound accumulators are NUMBER_WIDTH bits wide, capped at 16.
// Top level of the regex quantifier parser.
module regex_quantifier_parser_unit #(
	parameter int NUMBER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] rep_min,
	output logic [15:0] rep_max,
	output logic        unbounded,
	output logic [2:0]  status,
	output logic [7:0]  chars_consumed
);

	logic accept;
	logic res_valid;
	rqp_pkg::result_t res, head;

	assign accept = in_valid && in_ready;

	rqp_step #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.character(character),
		.res_valid(res_valid),
		.res      (res)
	);

	rqp_out_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.space    (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign rep_min        = head.rep_min;
	assign rep_max        = head.rep_max;
	assign unbounded      = head.unbounded;
	assign status         = head.status;
	assign chars_consumed = head.chars_consumed;

endmodule

// File: rtl/rqp_checker.sv
// Port-level assertions for the regex quantifier parser, bound to the top level.
module rqp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] rep_min,
	input logic [15:0] rep_max,
	input logic        unbounded,
	input logic [2:0]  status,
	input logic [7:0]  chars_consumed
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(rep_min) && $stable(rep_max)
			&& $stable(status) && $stable(chars_consumed))
		else $error("stalled result changed");

	a_unbounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unbounded |-> rep_max == 16'hFFFF && status == rqp_pkg::ST_OK)
		else $error("unbounded result without all-ones upper bound");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rqp_pkg::ST_OK |-> !unbounded
			&& (status == rqp_pkg::ST_UPPER_BELOW || status == rqp_pkg::ST_NO_BRACE
			|| status == rqp_pkg::ST_BAD_COMMA || status == rqp_pkg::ST_BAD_LOWER))
		else $error("bad error result");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rqp_pkg::ST_OK && chars_consumed == 8'd0
			|-> rep_min == 16'd1 && rep_max == 16'd1)
		else $error("empty quantifier with bounds other than 1,1");

endmodule

bind regex_quantifier_parser_unit rqp_checker u_rqp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.rep_min       (rep_min),
	.rep_max       (rep_max),
	.unbounded     (unbounded),
	.status        (status),
	.chars_consumed(chars_consumed)
);

// File: verif/tb_regex_quantifier_parser_unit.sv
// Self-checking testbench for the regex quantifier parser: directed and random patterns.
module tb_regex_quantifier_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] NUM_MAX  = 16'hFFFF;
	localparam logic [15:0] ALL_ONES = 16'hFFFF;
	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [7:0]  CH_MINUS = 8'h2D;
	localparam logic [7:0]  CH_NUL   = 8'h00;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  character = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] rep_min;
	logic [15:0] rep_max;
	logic        unbounded;
	logic [2:0]  status;
	logic [7:0]  chars_consumed;

	// parser state as predicted
	rqp_pkg::phase_t parse_phase = rqp_pkg::PH_IDLE;
	logic [15:0] lower_acc = '0;
	logic [15:0] upper_acc = '0;
	logic [7:0]  used_count = '0;

	rqp_pkg::result_t pending_results[$];
	int      fail_count = 0;
	int      chars_sent = 0;
	bit      no_gaps = 1'b0;
	int      hold_off_cycles = 0;

	regex_quantifier_parser_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.character      (character),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.rep_min        (rep_min),
		.rep_max        (rep_max),
		.unbounded      (unbounded),
		.status         (status),
		.chars_consumed (chars_consumed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] next_decimal(input logic [15:0] acc, input logic [3:0] d);
		logic [31:0] v;
		v = 32'(acc) * 32'd10 + 32'(d);
		return (v > 32'(NUM_MAX)) ? NUM_MAX : v[15:0];
	endfunction

	function automatic void count_char();
		if (used_count != 8'hFF)
			used_count = used_count + 8'd1;
	endfunction

	function automatic void close_parse(input logic [15:0] lo, input logic [15:0] hi,
			input logic unb, input rqp_pkg::status_t st);
		rqp_pkg::result_t r;
		r.rep_min        = lo;
		r.rep_max        = hi;
		r.unbounded      = unb;
		r.status         = st;
		r.chars_consumed = used_count;
		pending_results.push_back(r);
		parse_phase = rqp_pkg::PH_IDLE;
		lower_acc   = '0;
		upper_acc   = '0;
		used_count  = '0;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		logic       is_digit;
		logic [3:0] d;
		is_digit = (c >= rqp_pkg::CH_ZERO) && (c <= rqp_pkg::CH_NINE);
		d = 4'(c - rqp_pkg::CH_ZERO);
		case (parse_phase)
			rqp_pkg::PH_LOWER: begin
				if (is_digit) begin
					lower_acc = next_decimal(lower_acc, d);
					count_char();
				end else if (c == rqp_pkg::CH_RBRACE) begin
					count_char();
					close_parse(lower_acc, lower_acc, 1'b0, rqp_pkg::ST_OK);
				end else if (c == rqp_pkg::CH_COMMA) begin
					count_char();
					parse_phase = rqp_pkg::PH_COMMA;
				end else begin
					close_parse(lower_acc, '0, 1'b0, rqp_pkg::ST_BAD_LOWER);
				end
			end
			rqp_pkg::PH_COMMA: begin
				if (c == rqp_pkg::CH_RBRACE) begin
					count_char();
					close_parse(lower_acc, ALL_ONES, 1'b1, rqp_pkg::ST_OK);
				end else if (is_digit) begin
					upper_acc = 16'(d);
					count_char();
					parse_phase = rqp_pkg::PH_UPPER;
				end else begin
					close_parse(lower_acc, '0, 1'b0, rqp_pkg::ST_BAD_COMMA);
				end
			end
			rqp_pkg::PH_UPPER: begin
				if (is_digit) begin
					upper_acc = next_decimal(upper_acc, d);
					count_char();
				end else if (upper_acc < lower_acc) begin
					// bound order is checked before the closing brace
					close_parse(lower_acc, upper_acc, 1'b0, rqp_pkg::ST_UPPER_BELOW);
				end else if (c != rqp_pkg::CH_RBRACE) begin
					close_parse(lower_acc, upper_acc, 1'b0, rqp_pkg::ST_NO_BRACE);
				end else begin
					count_char();
					close_parse(lower_acc, upper_acc, 1'b0, rqp_pkg::ST_OK);
				end
			end
			default: begin
				used_count = '0;
				lower_acc  = '0;
				upper_acc  = '0;
				if (c == rqp_pkg::CH_QUESTION) begin
					count_char();
					close_parse(16'd0, 16'd1, 1'b0, rqp_pkg::ST_OK);
				end else if (c == rqp_pkg::CH_STAR) begin
					count_char();
					close_parse(16'd0, ALL_ONES, 1'b1, rqp_pkg::ST_OK);
				end else if (c == rqp_pkg::CH_PLUS) begin
					count_char();
					close_parse(16'd1, ALL_ONES, 1'b1, rqp_pkg::ST_OK);
				end else if (c == rqp_pkg::CH_LBRACE) begin
					count_char();
					parse_phase = rqp_pkg::PH_LOWER;
				end else begin
					// not a quantifier: the character is left for the caller
					close_parse(16'd1, 16'd1, 1'b0, rqp_pkg::ST_OK);
				end
			end
		endcase
	endfunction

	// Entered just after a rising edge; returns at the edge of the transfer.
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		character <= c;
		do
			@(posedge clk);
		while (!in_ready);
		parse_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_digits(input int n);
		for (int i = 0; i < n; i++)
			send_char(rqp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_nines(input int n);
		for (int i = 0; i < n; i++)
			send_char(rqp_pkg::CH_NINE);
	endtask

	task automatic check_result();
		rqp_pkg::result_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result: rep_min %0d rep_max %0d status %0d",
				rep_min, rep_max, status);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		if (rep_min !== want.rep_min) begin
			$error("rep_min: expected %0d, got %0d", want.rep_min, rep_min);
			fail_count++;
		end
		if (rep_max !== want.rep_max) begin
			$error("rep_max: expected %0d, got %0d", want.rep_max, rep_max);
			fail_count++;
		end
		if (unbounded !== want.unbounded) begin
			$error("unbounded: expected %0d, got %0d", want.unbounded, unbounded);
			fail_count++;
		end
		if (status !== 3'(want.status)) begin
			$error("status: expected %0d, got %0d", want.status, status);
			fail_count++;
		end
		if (chars_consumed !== want.chars_consumed) begin
			$error("chars_consumed: expected %0d, got %0d", want.chars_consumed,
				chars_consumed);
			fail_count++;
		end
	endtask

	// Result receiver with random stalls and an occasional long hold-off.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 9);
			end
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
				@(posedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			check_result();
		end
	end

	task automatic test_single_chars();
		send_char(rqp_pkg::CH_QUESTION);
		send_char(rqp_pkg::CH_STAR);
		send_char(rqp_pkg::CH_PLUS);
		send_char(CH_NUL);
		send_char(8'hFF);
	endtask

	task automatic test_brace_forms();
		send_text("{}");
		send_text("{,}");
		send_text("{9,3}");    // upper below lower
		send_text("{1,2x");    // no closing brace
		send_char(rqp_pkg::CH_LBRACE);  // whitespace ends the lower bound
		send_char(8'h31);
		send_char(CH_SPACE);
		send_char(rqp_pkg::CH_LBRACE);  // a sign after the comma is not a digit
		send_char(rqp_pkg::CH_COMMA);
		send_char(CH_MINUS);
	endtask

	task automatic test_saturation();
		send_text("{65535}");
		send_text("{65536,}");
		// long runs saturate both bounds and the consumed count
		send_char(rqp_pkg::CH_LBRACE);
		send_nines(300);
		send_char(rqp_pkg::CH_COMMA);
		send_nines(300);
		send_char(rqp_pkg::CH_RBRACE);
		send_text("{1,");
		send_nines(260);
		send_text("}");
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_off_cycles = 200;
		for (int i = 0; i < 40; i++)
			send_char((i % 2 == 0) ? rqp_pkg::CH_STAR : rqp_pkg::CH_QUESTION);
		no_gaps = 1'b0;
	endtask

	task automatic send_random_token();
		int kind;
		int term;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			send_char(8'($urandom_range(0, 255)));
		end else if (kind < 30) begin
			case ($urandom_range(0, 2))
				0: send_char(rqp_pkg::CH_QUESTION);
				1: send_char(rqp_pkg::CH_STAR);
				default: send_char(rqp_pkg::CH_PLUS);
			endcase
		end else begin
			send_char(rqp_pkg::CH_LBRACE);
			send_digits($urandom_range(0, 4));
			term = $urandom_range(0, 99);
			if (term < 10) begin
				send_char(8'($urandom_range(0, 255)));
			end else if (term < 30) begin
				send_char(rqp_pkg::CH_RBRACE);
			end else begin
				send_char(rqp_pkg::CH_COMMA);
				send_digits($urandom_range(0, 5));
				if ($urandom_range(0, 99) < 85)
					send_char(rqp_pkg::CH_RBRACE);
				else
					send_char(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_random(input int n_chars);
		int stop_at;
		stop_at = chars_sent + n_chars;
		no_gaps = 1'b1;
		while (chars_sent < stop_at) begin
			// start without idling, then flip between modes now and then
			if (chars_sent > stop_at - n_chars + 150 && $urandom_range(0, 39) == 0)
				no_gaps = !no_gaps;
			send_random_token();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_single_chars();
		test_brace_forms();
		test_saturation();
		test_backpressure();
		test_random(1100);

		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
rtl/rqp_pkg.sv
rtl/rqp_step.sv
rtl/rqp_out_buf.sv
rtl/regex_quantifier_parser_unit.sv
rtl/rqp_checker.sv
verif/tb_regex_quantifier_parser_unit.sv
